// ===== design/tlpw_pkg.sv =====
package tlpw_pkg;

  // Store geometry
  localparam int STORE_BYTES = 4096;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 5;
  localparam int PAGE_W      = ADDR_W - IDX_W;
  localparam int VA_W        = 3 * IDX_W;

  // Page-table entry layout
  localparam int ENTRY_VALID_BIT = BYTE_W - 1;
  localparam logic [PAGE_W-1:0] FAULT_FRAME    = PAGE_W'(127);
  localparam logic [PAGE_W-1:0] DIR_BASE_RESET = PAGE_W'(108);

  // Queue sizes
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int RES_DEPTH = 2;
  localparam int RES_PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Input operation codes
  typedef enum logic [1:0] {
    OP_LOAD_MEM  = 2'd0,
    OP_LOAD_DISK = 2'd1,
    OP_TRANSLATE = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_MEM_HIT   = 2'd0,
    ST_DISK_HIT  = 2'd1,
    ST_DIR_FAULT = 2'd2,
    ST_TAB_FAULT = 2'd3
  } status_t;

  // Work kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_MEM_LOAD  = 2'd0,
    CMD_DISK_LOAD = 2'd1,
    CMD_WALK      = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic [VA_W-1:0]   va;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] dir_entry;
    logic [BYTE_W-1:0] table_entry;
    logic [ADDR_W-1:0] phys_addr;
    logic [BYTE_W-1:0] value;
  } res_t;

  // Walk sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIR  = 4'b0010,
    S_TAB  = 4'b0100,
    S_DATA = 4'b1000
  } walk_state_t;

endpackage

// ===== design/tlpw_ram.sv =====
module tlpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/tlpw_front.sv =====
module tlpw_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [1:0]                     in_op,
  input  logic [tlpw_pkg::ADDR_W-1:0]    in_load_address,
  input  logic [tlpw_pkg::BYTE_W-1:0]    in_load_data,
  input  logic [tlpw_pkg::VA_W-1:0]      in_virtual_address,
  output logic                           full,
  output logic                           cmd_valid,
  output tlpw_pkg::cmd_t                 cmd,
  input  logic                           cmd_pop
);

  tlpw_pkg::cmd_t                 cmd_q_r [tlpw_pkg::CMD_DEPTH];
  logic [tlpw_pkg::CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tlpw_pkg::CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tlpw_pkg::CMD_CNT_W-1:0] count_r, count_nxt;
  tlpw_pkg::cmd_t                 new_cmd;
  logic                           keep;
  logic                           enq;
  logic                           deq;

  // Classify the incoming item; drop the unused op code
  always_comb begin
    new_cmd.kind = tlpw_pkg::CMD_WALK;
    new_cmd.addr = in_load_address;
    new_cmd.data = in_load_data;
    new_cmd.va   = in_virtual_address;
    keep         = 1'b1;
    case (in_op)
      tlpw_pkg::OP_LOAD_MEM:  new_cmd.kind = tlpw_pkg::CMD_MEM_LOAD;
      tlpw_pkg::OP_LOAD_DISK: new_cmd.kind = tlpw_pkg::CMD_DISK_LOAD;
      tlpw_pkg::OP_TRANSLATE: new_cmd.kind = tlpw_pkg::CMD_WALK;
      default:                keep = 1'b0;
    endcase
  end

  assign full      = (count_r == tlpw_pkg::CMD_CNT_W'(tlpw_pkg::CMD_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = cmd_q_r[rd_ptr_r];
  assign enq       = push && !full && keep;
  assign deq       = cmd_pop && cmd_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == tlpw_pkg::CMD_PTR_W'(tlpw_pkg::CMD_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == tlpw_pkg::CMD_PTR_W'(tlpw_pkg::CMD_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({enq, deq})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (enq) begin
      cmd_q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== design/tlpw_back.sv =====
module tlpw_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tlpw_pkg::PAGE_W-1:0]   cfg_wr_data,
  input  logic                          cmd_valid,
  input  tlpw_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  input  logic                          res_space,
  output logic                          res_push,
  output tlpw_pkg::res_t                res
);

  localparam int VB = tlpw_pkg::ENTRY_VALID_BIT;

  tlpw_pkg::walk_state_t             state_r, state_nxt;
  logic [tlpw_pkg::PAGE_W-1:0]       dir_base_r;
  logic [tlpw_pkg::IDX_W-1:0]        tab_idx_r, tab_idx_nxt;
  logic [tlpw_pkg::IDX_W-1:0]        off_r, off_nxt;
  logic [tlpw_pkg::BYTE_W-1:0]       dent_r, dent_nxt;
  logic [tlpw_pkg::BYTE_W-1:0]       tent_r, tent_nxt;
  logic [tlpw_pkg::ADDR_W-1:0]       pa_r, pa_nxt;

  logic                              mem_we, disk_we;
  logic                              mem_re, disk_re;
  logic [tlpw_pkg::ADDR_W-1:0]       mem_raddr;
  logic [tlpw_pkg::BYTE_W-1:0]       mem_rdata, disk_rdata;
  logic [tlpw_pkg::ADDR_W-1:0]       pa_now;

  // Physical memory and swap disk
  tlpw_ram #(
    .WIDTH(tlpw_pkg::BYTE_W),
    .DEPTH(tlpw_pkg::STORE_BYTES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (cmd.addr),
    .wr_data (cmd.data),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  tlpw_ram #(
    .WIDTH(tlpw_pkg::BYTE_W),
    .DEPTH(tlpw_pkg::STORE_BYTES)
  ) u_disk (
    .clk     (clk),
    .wr_en   (disk_we),
    .wr_addr (cmd.addr),
    .wr_data (cmd.data),
    .rd_en   (disk_re),
    .rd_addr (pa_now),
    .rd_data (disk_rdata)
  );

  // Frame of the table byte just read, joined with the offset
  assign pa_now = {mem_rdata[tlpw_pkg::PAGE_W-1:0], off_r};

  // Walk sequencer
  always_comb begin
    state_nxt   = state_r;
    tab_idx_nxt = tab_idx_r;
    off_nxt     = off_r;
    dent_nxt    = dent_r;
    tent_nxt    = tent_r;
    pa_nxt      = pa_r;
    cmd_pop     = 1'b0;
    mem_we      = 1'b0;
    disk_we     = 1'b0;
    mem_re      = 1'b0;
    disk_re     = 1'b0;
    mem_raddr   = {dir_base_r, cmd.va[tlpw_pkg::VA_W-1 -: tlpw_pkg::IDX_W]};
    res_push    = 1'b0;
    res         = '0;
    case (state_r)
      tlpw_pkg::S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            tlpw_pkg::CMD_MEM_LOAD: begin
              cmd_pop = 1'b1;
              mem_we  = 1'b1;
            end
            tlpw_pkg::CMD_DISK_LOAD: begin
              cmd_pop = 1'b1;
              disk_we = 1'b1;
            end
            tlpw_pkg::CMD_WALK: begin
              // start only with a result slot reserved
              if (res_space) begin
                cmd_pop     = 1'b1;
                mem_re      = 1'b1;
                tab_idx_nxt = cmd.va[2*tlpw_pkg::IDX_W-1 -: tlpw_pkg::IDX_W];
                off_nxt     = cmd.va[tlpw_pkg::IDX_W-1:0];
                state_nxt   = tlpw_pkg::S_DIR;
              end
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      tlpw_pkg::S_DIR: begin
        dent_nxt = mem_rdata;
        if (!mem_rdata[VB]) begin
          res_push      = 1'b1;
          res.status    = tlpw_pkg::ST_DIR_FAULT;
          res.dir_entry = mem_rdata;
          state_nxt     = tlpw_pkg::S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = {mem_rdata[tlpw_pkg::PAGE_W-1:0], tab_idx_r};
          state_nxt = tlpw_pkg::S_TAB;
        end
      end
      tlpw_pkg::S_TAB: begin
        tent_nxt  = mem_rdata;
        pa_nxt    = pa_now;
        mem_raddr = pa_now;
        if (mem_rdata[VB]) begin
          mem_re    = 1'b1;
          state_nxt = tlpw_pkg::S_DATA;
        end else if (mem_rdata[tlpw_pkg::PAGE_W-1:0] != tlpw_pkg::FAULT_FRAME) begin
          disk_re   = 1'b1;
          state_nxt = tlpw_pkg::S_DATA;
        end else begin
          res_push        = 1'b1;
          res.status      = tlpw_pkg::ST_TAB_FAULT;
          res.dir_entry   = dent_r;
          res.table_entry = mem_rdata;
          res.phys_addr   = pa_now;
          state_nxt       = tlpw_pkg::S_IDLE;
        end
      end
      tlpw_pkg::S_DATA: begin
        res_push        = 1'b1;
        res.status      = tent_r[VB] ? tlpw_pkg::ST_MEM_HIT : tlpw_pkg::ST_DISK_HIT;
        res.dir_entry   = dent_r;
        res.table_entry = tent_r;
        res.phys_addr   = pa_r;
        res.value       = tent_r[VB] ? mem_rdata : disk_rdata;
        state_nxt       = tlpw_pkg::S_IDLE;
      end
      default: state_nxt = tlpw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tlpw_pkg::S_IDLE;
      dir_base_r <= tlpw_pkg::DIR_BASE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        dir_base_r <= cfg_wr_data;
      end
    end
  end

  // Hold walk context
  always_ff @(posedge clk) begin
    tab_idx_r <= tab_idx_nxt;
    off_r     <= off_nxt;
    dent_r    <= dent_nxt;
    tent_r    <= tent_nxt;
    pa_r      <= pa_nxt;
  end

endmodule

// ===== design/tlpw_resq.sv =====
module tlpw_resq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_push,
  input  tlpw_pkg::res_t res,
  output logic           res_space,
  output logic           empty,
  input  logic           pop,
  output tlpw_pkg::res_t head
);

  tlpw_pkg::res_t                 res_q_r [tlpw_pkg::RES_DEPTH];
  logic [tlpw_pkg::RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tlpw_pkg::RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tlpw_pkg::RES_CNT_W-1:0] count_r, count_nxt;
  logic                           enq;
  logic                           deq;

  assign res_space = (count_r != tlpw_pkg::RES_CNT_W'(tlpw_pkg::RES_DEPTH));
  assign empty     = (count_r == '0);
  assign head      = res_q_r[rd_ptr_r];
  assign enq       = res_push;
  assign deq       = pop && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == tlpw_pkg::RES_PTR_W'(tlpw_pkg::RES_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == tlpw_pkg::RES_PTR_W'(tlpw_pkg::RES_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({enq, deq})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the result
  always_ff @(posedge clk) begin
    if (enq) begin
      res_q_r[wr_ptr_r] <= res;
    end
  end

endmodule

// ===== design/two_level_page_walk.sv =====
// Channel   | Transfer when     | Ports
// ----------+-------------------+-------------------------------------------------
// input     | push && !full     | in_op, in_load_address, in_load_data,
//           |                   | in_virtual_address
// result    | pop && !empty     | out_status, out_directory_entry, out_table_entry,
//           |                   | out_physical_address, out_value
// config    | cfg_wr_en         | cfg_wr_data (directory base page)
//
// A load is handled while the walker idles; a translation passes through dispatch, then
// the directory, table and data reads through the registered RAM port; a directory fault
// ends at the directory read and a table fault at the table read. Reset empties both
// queues, idles the walker and sets the directory base page to 108; memory and disk keep
// their contents. Both queues are 2 deep; a walk starts only with a result slot free, so a
// stalled result side backs up into full once both queues fill.
module two_level_page_walk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_op,
  input  logic [tlpw_pkg::ADDR_W-1:0]   in_load_address,
  input  logic [tlpw_pkg::BYTE_W-1:0]   in_load_data,
  input  logic [tlpw_pkg::VA_W-1:0]     in_virtual_address,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    out_status,
  output logic [tlpw_pkg::BYTE_W-1:0]   out_directory_entry,
  output logic [tlpw_pkg::BYTE_W-1:0]   out_table_entry,
  output logic [tlpw_pkg::ADDR_W-1:0]   out_physical_address,
  output logic [tlpw_pkg::BYTE_W-1:0]   out_value,
  input  logic                          cfg_wr_en,
  input  logic [tlpw_pkg::PAGE_W-1:0]   cfg_wr_data
);

  logic           cmd_valid;
  logic           cmd_pop;
  tlpw_pkg::cmd_t cmd;
  logic           res_space;
  logic           res_push;
  tlpw_pkg::res_t res;
  tlpw_pkg::res_t head;

  // Accept and classify
  tlpw_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .in_op              (in_op),
    .in_load_address    (in_load_address),
    .in_load_data       (in_load_data),
    .in_virtual_address (in_virtual_address),
    .full               (full),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_pop            (cmd_pop)
  );

  // Execute loads and walks
  tlpw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res_space   (res_space),
    .res_push    (res_push),
    .res         (res)
  );

  // Buffer results
  tlpw_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_space (res_space),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign out_status           = head.status;
  assign out_directory_entry  = head.dir_entry;
  assign out_table_entry      = head.table_entry;
  assign out_physical_address = head.phys_addr;
  assign out_value            = head.value;

endmodule

// ===== design/tlpw_checker.sv =====
module tlpw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [1:0]                  out_status,
  input logic [tlpw_pkg::BYTE_W-1:0] out_directory_entry,
  input logic [tlpw_pkg::BYTE_W-1:0] out_table_entry,
  input logic [tlpw_pkg::ADDR_W-1:0] out_physical_address,
  input logic [tlpw_pkg::BYTE_W-1:0] out_value
);

  localparam int VB = tlpw_pkg::ENTRY_VALID_BIT;

  // Both queues come out of reset drained
  a_reset_drained: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not drained after reset");

  // A waiting result holds until transferred
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_status) &&
                          $stable(out_physical_address) && $stable(out_value)))
    else $error("waiting result changed before transfer");

  // Directory fault: invalid directory byte, other fields zero
  a_dir_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == tlpw_pkg::ST_DIR_FAULT) |->
      (!out_directory_entry[VB] && out_table_entry == '0 &&
       out_physical_address == '0 && out_value == '0))
    else $error("directory fault fields wrong");

  // Table fault: invalid entry pointing at the fault frame, no data
  a_tab_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == tlpw_pkg::ST_TAB_FAULT) |->
      (out_directory_entry[VB] && !out_table_entry[VB] &&
       out_table_entry[tlpw_pkg::PAGE_W-1:0] == tlpw_pkg::FAULT_FRAME &&
       out_value == '0))
    else $error("table fault fields wrong");

  // Hits carry the frame of the table byte in the physical address
  a_hit_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status == tlpw_pkg::ST_MEM_HIT ||
                out_status == tlpw_pkg::ST_DISK_HIT)) |->
      (out_directory_entry[VB] &&
       out_table_entry[VB] == (out_status == tlpw_pkg::ST_MEM_HIT) &&
       out_physical_address[tlpw_pkg::ADDR_W-1 -: tlpw_pkg::PAGE_W] ==
         out_table_entry[tlpw_pkg::PAGE_W-1:0]))
    else $error("hit result inconsistent with table entry");

endmodule

bind two_level_page_walk tlpw_checker u_tlpw_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .full                 (full),
  .empty                (empty),
  .pop                  (pop),
  .out_status           (out_status),
  .out_directory_entry  (out_directory_entry),
  .out_table_entry      (out_table_entry),
  .out_physical_address (out_physical_address),
  .out_value            (out_value)
);
